FILE: src/cft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cft_pkg;

  localparam int DEFAULT_BUCKETS = 2048;
  localparam int DEFAULT_WAYS    = 4;

  localparam int SUM_W   = 32;
  // Key is {big_addr, small_addr, proto_num, big_port, small_port}.
  localparam int KEY_W   = 104;
  // Entry is {key, syn, synack, ack, app_type}.
  localparam int META_W  = 11;
  localparam int ENTRY_W = KEY_W + META_W;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_FILL_RD,
    S_DECIDE,
    S_ENT_RD,
    S_CMP,
    S_SHIFT,
    S_SHIFT_WR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: src/cft_hash.sv
`timescale 1ns / 1ps
`default_nettype none

module cft_hash import cft_pkg::*; #(
  parameter int BUCKETS = DEFAULT_BUCKETS,
  localparam int BW = $clog2(BUCKETS)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [31:0]   big_addr,
  input  wire logic [31:0]   small_addr,
  input  wire logic [7:0]    proto_num,
  input  wire logic [15:0]   big_port,
  input  wire logic [15:0]   small_port,
  output logic               done,
  output logic [BW-1:0]      bucket
);

  localparam bit POW2    = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam int MUL_AW  = 32;
  localparam int MUL_BW  = 17;
  localparam int MUL_PW  = MUL_AW + MUL_BW;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  // Rounded-up reciprocal of the bucket count. For any 32-bit sum,
  // (sum * RECIP) >> (32 + BW) is the exact quotient.
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << (SUM_W + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  localparam logic [1:0] STEP_LO  = 2'd0;
  localparam logic [1:0] STEP_HI  = 2'd1;
  localparam logic [1:0] STEP_REM = 2'd2;

  logic                busy;
  logic [1:0]          step;
  logic [SUM_W-1:0]    sum;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    quot;
  logic [MUL_AW-1:0]   mul_a;
  logic [MUL_BW-1:0]   mul_b;
  logic [MUL_PW-1:0]   mul_p;
  logic [SUM_W-1:0]    rem;

  // One multiplier serves all three steps: the low and the high part of the
  // reciprocal product, then the quotient times the bucket count.
  assign quot = SUM_W'(prod >> (SUM_W + BW));

  always_comb begin
    unique case (step)
      STEP_LO: begin
        mul_a = sum;
        mul_b = RECIP[MUL_BW-1:0];
      end
      STEP_HI: begin
        mul_a = sum;
        mul_b = MUL_BW'(RECIP[RECIP_W-1:MUL_BW]);
      end
      default: begin
        mul_a = quot;
        mul_b = MUL_BW'(BUCKETS);
      end
    endcase
  end

  assign mul_p  = MUL_PW'(mul_a) * MUL_PW'(mul_b);
  assign rem    = sum - mul_p[SUM_W-1:0];
  assign done   = busy && (POW2 || step == STEP_REM);
  assign bucket = POW2 ? sum[BW-1:0] : rem[BW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_LO;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_LO;
    end else if (busy) begin
      if (done) begin
        busy <= 1'b0;
      end else begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum <= big_addr + small_addr + SUM_W'(proto_num) + SUM_W'(big_port) +
             SUM_W'(small_port);
    end else if (busy && !POW2) begin
      if (step == STEP_LO) begin
        prod <= PROD_W'(mul_p);
      end else if (step == STEP_HI) begin
        prod <= prod + (PROD_W'(mul_p) << MUL_BW);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/connection_flow_table_top.sv
`timescale 1ns / 1ps
`default_nettype none

// A beat goes through the hash, a fill-count read and a decision; an insert, an unused kind, or
// a delete or search on an empty bucket goes to the result. A delete or search compares the
// entries one at a time; a matched delete moves each later entry down a slot. A bucket count
// that is not a power of two adds the reciprocal remainder steps to the hash. The input stalls
// until the result is loaded into the output register; a stalled result there holds off the
// next. After reset the bucket fill counts are cleared one per cycle, with in_stall high.
module connection_flow_table_top import cft_pkg::*; #(
  parameter int BUCKETS = DEFAULT_BUCKETS,
  parameter int WAYS    = DEFAULT_WAYS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] big_addr,
  input  wire logic [31:0] small_addr,
  input  wire logic [7:0]  proto_num,
  input  wire logic [15:0] big_port,
  input  wire logic [15:0] small_port,
  input  wire logic        syn_seen,
  input  wire logic        synack_seen,
  input  wire logic        ack_seen,
  input  wire logic [7:0]  app_type,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic             hit_syn,
  output logic             hit_synack,
  output logic             hit_ack,
  output logic [7:0]       hit_type
);

  localparam int BW = $clog2(BUCKETS);
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(WAYS + 1);
  localparam int AW = BW + WW;

  state_t state, state_next;

  logic [1:0]         req_kind;
  logic [ENTRY_W-1:0] req_entry;
  logic [BW-1:0]      bucket;
  logic [BW-1:0]      clr_cnt;
  logic [WW-1:0]      way;
  logic [CW-1:0]      n;

  logic [1:0]         res_status;
  logic [META_W-1:0]  res_meta;

  logic [ENTRY_W-1:0] entry_mem [BUCKETS << WW];
  logic [CW-1:0]      fill_mem [BUCKETS];
  logic [ENTRY_W-1:0] ent_q;
  logic [CW-1:0]      fill_q;

  logic               ent_we;
  logic [AW-1:0]      ent_waddr;
  logic [ENTRY_W-1:0] ent_wdata;
  logic [AW-1:0]      ent_raddr;
  logic               fill_we;
  logic [BW-1:0]      fill_waddr;
  logic [CW-1:0]      fill_wdata;

  logic               hash_done;
  logic [BW-1:0]      hash_bucket;
  logic               accept;
  logic               key_match;
  logic               last_way;
  logic               more_to_shift;
  logic               out_load;

  assign accept        = in_valid && !in_stall;
  assign in_stall      = (state != S_IDLE);
  assign key_match     = (ent_q[ENTRY_W-1:META_W] == req_entry[ENTRY_W-1:META_W]);
  assign last_way      = ((CW'(way) + CW'(1)) == n);
  assign more_to_shift = ((CW'(way) + CW'(1)) < n);
  assign out_load      = (state == S_DONE) && (!out_valid || !out_stall);

  cft_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .big_addr   (big_addr),
    .small_addr (small_addr),
    .proto_num  (proto_num),
    .big_port   (big_port),
    .small_port (small_port),
    .done       (hash_done),
    .bucket     (hash_bucket)
  );

  // Storage: one write and one registered read per cycle on each memory.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= ent_wdata;
    end
    ent_q <= entry_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_q <= fill_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ent_we     = 1'b0;
    ent_waddr  = {bucket, way};
    ent_wdata  = ent_q;
    ent_raddr  = {bucket, way};
    fill_we    = 1'b0;
    fill_waddr = bucket;
    fill_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_cnt;
        if (clr_cnt == BW'(BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_next = S_FILL_RD;
        end
      end
      S_FILL_RD: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (req_kind == KIND_INSERT) begin
          if (fill_q != CW'(WAYS)) begin
            ent_we     = 1'b1;
            ent_waddr  = {bucket, WW'(fill_q)};
            ent_wdata  = req_entry;
            fill_we    = 1'b1;
            fill_wdata = fill_q + CW'(1);
          end
          state_next = S_DONE;
        end else if ((req_kind == KIND_DELETE || req_kind == KIND_SEARCH) &&
                     fill_q != '0) begin
          state_next = S_ENT_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_ENT_RD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (key_match) begin
          state_next = (req_kind == KIND_DELETE) ? S_SHIFT : S_DONE;
        end else if (last_way) begin
          state_next = S_DONE;
        end else begin
          state_next = S_ENT_RD;
        end
      end
      S_SHIFT: begin
        if (more_to_shift) begin
          ent_raddr  = {bucket, WW'(way + WW'(1))};
          state_next = S_SHIFT_WR;
        end else begin
          fill_we    = 1'b1;
          fill_wdata = n - CW'(1);
          state_next = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        // The later entry read in the previous cycle moves down one slot.
        ent_we     = 1'b1;
        state_next = S_SHIFT;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == S_CLEAR) begin
      clr_cnt <= clr_cnt + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind  <= kind;
      req_entry <= {big_addr, small_addr, proto_num, big_port, small_port,
                    syn_seen, synack_seen, ack_seen, app_type};
    end
    if (state == S_HASH && hash_done) begin
      bucket <= hash_bucket;
    end
    unique case (state)
      S_DECIDE: begin
        n        <= fill_q;
        way      <= '0;
        res_meta <= '0;
        if (req_kind == KIND_INSERT) begin
          res_status <= (fill_q == CW'(WAYS)) ? ST_FULL : ST_OK;
        end else begin
          res_status <= ST_MISS;
        end
      end
      S_CMP: begin
        if (key_match) begin
          res_status <= ST_OK;
          if (req_kind == KIND_SEARCH) begin
            res_meta <= ent_q[META_W-1:0];
          end
        end else if (!last_way) begin
          way <= way + WW'(1);
        end
      end
      S_SHIFT_WR: begin
        way <= way + WW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= res_status;
      hit_syn    <= res_meta[10];
      hit_synack <= res_meta[9];
      hit_ack    <= res_meta[8];
      hit_type   <= res_meta[7:0];
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_we |-> fill_wdata <= CW'(WAYS))
    else $error("bucket fill count written above the way count");

  a_entry_write_states: assert property (@(posedge clk) disable iff (rst)
    ent_we |-> (state == S_DECIDE || state == S_SHIFT_WR))
    else $error("entry written outside insert or shift");

  a_accept_starts_hash: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_HASH)
    else $error("accepted request did not start the hash");

  a_scan_within_fill: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> CW'(way) < n)
    else $error("scan compared a slot beyond the bucket fill");

  a_hash_done_expected: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> state == S_HASH)
    else $error("hash finished while no request waited for it");

endmodule

`default_nettype wire

FILE: verif/connection_flow_table_top_tb.sv
`timescale 1ns / 1ps

module connection_flow_table_top_tb import cft_pkg::*;;

  localparam int BUCKETS = DEFAULT_BUCKETS;
  localparam int WAYS    = DEFAULT_WAYS;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int POOL_SIZE    = 24;
  localparam int HOT_COUNT    = 6;
  localparam int RANDOM_ITEMS = 780;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] big_addr;
    logic [31:0] small_addr;
    logic [7:0]  proto_num;
    logic [15:0] big_port;
    logic [15:0] small_port;
    logic        syn_seen;
    logic        synack_seen;
    logic        ack_seen;
    logic [7:0]  app_type;
  } flow_req_t;

  typedef struct {
    logic [1:0] status;
    logic       syn;
    logic       synack;
    logic       ack;
    logic [7:0] app_type;
  } flow_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = '0;
  logic [31:0] big_addr = '0;
  logic [31:0] small_addr = '0;
  logic [7:0]  proto_num = '0;
  logic [15:0] big_port = '0;
  logic [15:0] small_port = '0;
  logic        syn_seen = 1'b0;
  logic        synack_seen = 1'b0;
  logic        ack_seen = 1'b0;
  logic [7:0]  app_type = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic        hit_syn;
  logic        hit_synack;
  logic        hit_ack;
  logic [7:0]  hit_type;

  connection_flow_table_top #(
    .BUCKETS(BUCKETS),
    .WAYS(WAYS)
  ) u_top (
    .clk, .rst, .in_valid, .in_stall, .kind, .big_addr, .small_addr, .proto_num,
    .big_port, .small_port, .syn_seen, .synack_seen, .ack_seen, .app_type,
    .out_valid, .out_stall, .status, .hit_syn, .hit_synack, .hit_ack, .hit_type
  );

  always #5 clk = ~clk;

  // Shadow copy of the connection table.
  flow_req_t   flow_tbl [BUCKETS][WAYS];
  int unsigned fill_cnt [BUCKETS];
  flow_resp_t  expected_resp [$];

  flow_req_t   key_pool [POOL_SIZE];
  int unsigned hot_buckets [HOT_COUNT];

  bit          idle_on = 1'b1;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned n_stored = 0, n_full = 0, n_del_hit = 0, n_search_hit = 0, n_miss = 0;

  function automatic logic [31:0] key_sum(input flow_req_t k);
    return k.big_addr + k.small_addr + 32'(k.proto_num) + 32'(k.big_port) +
           32'(k.small_port);
  endfunction

  function automatic int unsigned bucket_of(input flow_req_t k);
    logic [31:0] sum;
    sum = key_sum(k);
    return sum % 32'(BUCKETS);
  endfunction

  function automatic bit same_flow(input flow_req_t a, input flow_req_t b);
    return a.big_addr == b.big_addr && a.small_addr == b.small_addr &&
           a.proto_num == b.proto_num && a.big_port == b.big_port &&
           a.small_port == b.small_port;
  endfunction

  // Applies one request to the shadow table and returns the answer it should give.
  function automatic flow_resp_t flow_table_apply(input flow_req_t r);
    flow_resp_t  res;
    int unsigned b;
    int unsigned n;
    int unsigned w;
    res.status = ST_MISS;
    res.syn = 1'b0;
    res.synack = 1'b0;
    res.ack = 1'b0;
    res.app_type = '0;
    b = bucket_of(r);
    n = fill_cnt[b];
    w = WAYS;
    for (int unsigned i = 0; i < n; i++) begin
      if (w == WAYS && same_flow(flow_tbl[b][i], r)) w = i;
    end
    case (r.kind)
      KIND_INSERT: begin
        if (n >= WAYS) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          flow_tbl[b][n] = r;
          fill_cnt[b] = n + 1;
          res.status = ST_OK;
          n_stored++;
        end
      end
      KIND_DELETE: begin
        if (w < n) begin
          for (int unsigned i = w; i + 1 < n; i++) flow_tbl[b][i] = flow_tbl[b][i + 1];
          fill_cnt[b] = n - 1;
          res.status = ST_OK;
          n_del_hit++;
        end
      end
      KIND_SEARCH: begin
        if (w < n) begin
          res.status = ST_OK;
          res.syn = flow_tbl[b][w].syn_seen;
          res.synack = flow_tbl[b][w].synack_seen;
          res.ack = flow_tbl[b][w].ack_seen;
          res.app_type = flow_tbl[b][w].app_type;
          n_search_hit++;
        end
      end
      default: ;
    endcase
    if (res.status == ST_MISS) n_miss++;
    return res;
  endfunction

  function automatic flow_req_t fresh_flow();
    flow_req_t k;
    k.kind = KIND_SEARCH;
    k.big_addr = $urandom;
    k.small_addr = $urandom;
    k.proto_num = 8'($urandom);
    k.big_port = 16'($urandom);
    k.small_port = 16'($urandom);
    // Now and then push fields to their ends so the hash sum wraps or stays tiny.
    if ($urandom_range(9) == 0) k.big_addr = '1;
    if ($urandom_range(9) == 0) k.small_addr = '1;
    if ($urandom_range(9) == 0) k.proto_num = $urandom_range(1) ? 8'hff : 8'h00;
    if ($urandom_range(9) == 0) k.big_port = $urandom_range(1) ? 16'hffff : 16'h0000;
    if ($urandom_range(9) == 0) k.small_port = $urandom_range(1) ? 16'hffff : 16'h0000;
    k.syn_seen = 1'($urandom);
    k.synack_seen = 1'($urandom);
    k.ack_seen = 1'($urandom);
    k.app_type = 8'($urandom);
    return k;
  endfunction

  // Random key whose hash lands in bucket b; big_addr is raised by less than BUCKETS.
  function automatic flow_req_t flow_in_bucket(input int unsigned b);
    flow_req_t   k;
    logic [31:0] sum;
    k = fresh_flow();
    sum = key_sum(k);
    k.big_addr = k.big_addr + ((b - sum) & (BUCKETS - 1));
    return k;
  endfunction

  function automatic flow_req_t as_req(input flow_req_t k, input logic [1:0] op,
                                       input logic [10:0] meta);
    flow_req_t r;
    r = k;
    r.kind = op;
    {r.syn_seen, r.synack_seen, r.ack_seen, r.app_type} = meta;
    return r;
  endfunction

  function automatic flow_req_t random_request();
    flow_req_t   r;
    int unsigned p;
    if ($urandom_range(99) < 20) r = fresh_flow();
    else r = key_pool[$urandom_range(POOL_SIZE - 1)];
    p = $urandom_range(99);
    r.kind = p < 36 ? KIND_INSERT : p < 66 ? KIND_DELETE : p < 95 ? KIND_SEARCH : KIND_UNUSED;
    r.syn_seen = 1'($urandom);
    r.synack_seen = 1'($urandom);
    r.ack_seen = 1'($urandom);
    r.app_type = 8'($urandom);
    if ($urandom_range(19) == 0)
      key_pool[$urandom_range(POOL_SIZE - 1)] =
        flow_in_bucket(hot_buckets[$urandom_range(HOT_COUNT - 1)]);
    return r;
  endfunction

  task automatic send_req(input flow_req_t r);
    in_valid <= 1'b1;
    kind <= r.kind;
    big_addr <= r.big_addr;
    small_addr <= r.small_addr;
    proto_num <= r.proto_num;
    big_port <= r.big_port;
    small_port <= r.small_port;
    syn_seen <= r.syn_seen;
    synack_seen <= r.synack_seen;
    ack_seen <= r.ack_seen;
    app_type <= r.app_type;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_resp.push_back(flow_table_apply(r));
    if (idle_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_resp.size() != 0);
  endtask

  task automatic test_empty_table();
    flow_req_t k;
    k = flow_in_bucket(7);
    send_req(as_req(k, KIND_SEARCH, 11'h7ff));
    send_req(as_req(k, KIND_DELETE, 11'h000));
    wait_drained();
  endtask

  task automatic test_insert_search_extremes();
    flow_req_t lo;
    flow_req_t hi;
    lo = as_req(fresh_flow(), KIND_INSERT, 11'h000);
    lo.big_addr = '0;
    lo.small_addr = '0;
    lo.proto_num = '0;
    lo.big_port = '0;
    lo.small_port = '0;
    hi = as_req(fresh_flow(), KIND_INSERT, 11'h7ff);
    hi.big_addr = '1;
    hi.small_addr = '1;
    hi.proto_num = '1;
    hi.big_port = '1;
    hi.small_port = '1;
    send_req(lo);
    send_req(hi);
    send_req(as_req(lo, KIND_SEARCH, 11'h7ff));
    send_req(as_req(hi, KIND_SEARCH, 11'h000));
    send_req(as_req(hi, KIND_DELETE, 11'h000));
    send_req(as_req(hi, KIND_SEARCH, 11'h000));
    wait_drained();
  endtask

  // Fills the top bucket with a duplicate inside, then deletes so entries move down.
  task automatic test_bucket_overflow();
    flow_req_t a;
    flow_req_t c;
    flow_req_t d;
    a = flow_in_bucket(BUCKETS - 1);
    c = flow_in_bucket(BUCKETS - 1);
    d = flow_in_bucket(BUCKETS - 1);
    send_req(as_req(a, KIND_INSERT, {3'b100, 8'h11}));
    send_req(as_req(c, KIND_INSERT, {3'b010, 8'h22}));
    send_req(as_req(a, KIND_INSERT, {3'b001, 8'h33}));
    send_req(as_req(d, KIND_INSERT, {3'b111, 8'ha5}));
    send_req(as_req(c, KIND_INSERT, {3'b111, 8'hff}));
    send_req(as_req(a, KIND_SEARCH, 11'h000));
    send_req(as_req(a, KIND_DELETE, 11'h000));
    send_req(as_req(a, KIND_SEARCH, 11'h000));
    send_req(as_req(d, KIND_SEARCH, 11'h000));
    send_req(as_req(c, KIND_DELETE, 11'h000));
    send_req(as_req(d, KIND_SEARCH, 11'h000));
    send_req(as_req(flow_in_bucket(BUCKETS - 1), KIND_DELETE, 11'h000));
    send_req(as_req(c, KIND_INSERT, {3'b011, 8'h5a}));
    wait_drained();
  endtask

  task automatic test_unused_kind();
    flow_req_t k;
    k = flow_in_bucket(9);
    send_req(as_req(k, KIND_INSERT, {3'b101, 8'h80}));
    send_req(as_req(k, KIND_UNUSED, 11'h7ff));
    send_req(as_req(k, KIND_SEARCH, 11'h000));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    hot_buckets[0] = 0;
    hot_buckets[1] = BUCKETS - 1;
    hot_buckets[2] = 251;
    for (int i = 3; i < HOT_COUNT; i++) hot_buckets[i] = $urandom_range(BUCKETS - 1);
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = flow_in_bucket(hot_buckets[$urandom_range(HOT_COUNT - 1)]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 200) idle_on = 1'b0;
      if (i == 350) idle_on = 1'b1;
      if (i % 150 == 149) wait_drained();
      send_req(random_request());
    end
    wait_drained();
  endtask

  // The result side holds off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_reqs++;
    for (int i = 0; i < 20; i++) send_req(random_request());
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_done != hold_reqs) begin
      hold_left = HOLD_CYCLES;
      hold_done++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    flow_resp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_resp.size() == 0) begin
        $error("result beat with nothing expected: status %0d", status);
        fail_cnt++;
      end else begin
        want = expected_resp.pop_front();
        results_seen++;
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          fail_cnt++;
        end
        if (hit_syn !== want.syn) begin
          $error("hit_syn: expected %0d, actual %0d", want.syn, hit_syn);
          fail_cnt++;
        end
        if (hit_synack !== want.synack) begin
          $error("hit_synack: expected %0d, actual %0d", want.synack, hit_synack);
          fail_cnt++;
        end
        if (hit_ack !== want.ack) begin
          $error("hit_ack: expected %0d, actual %0d", want.ack, hit_ack);
          fail_cnt++;
        end
        if (hit_type !== want.app_type) begin
          $error("hit_type: expected %0d, actual %0d", want.app_type, hit_type);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_resp.size());
      $display("[connection_flow_table_top] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_insert_search_extremes();
    test_bucket_overflow();
    test_unused_kind();
    test_random_traffic();
    test_backpressure();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_resp.size() != 0) begin
      $error("%0d expected results never arrived", expected_resp.size());
      fail_cnt++;
    end
    $display("%0d requests checked: %0d inserts stored, %0d refused on a full bucket,",
             results_seen, n_stored, n_full);
    $display("%0d deletes and %0d searches matched, %0d misses or unused requests",
             n_del_hit, n_search_hit, n_miss);
    if (fail_cnt == 0) begin
      $display("[connection_flow_table_top] OK");
    end else begin
      $display("[connection_flow_table_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: connection_flow_table_top.f
src/cft_pkg.sv
src/cft_hash.sv
src/connection_flow_table_top.sv
verif/connection_flow_table_top_tb.sv
